>>> rtl/prrt_pkg.sv
// Shared types and constants for the port range reservation table.
// No dependencies; prrt_cell and port_range_reservation_table import this package.
package prrt_pkg;

    localparam int HANDLE_BITS  = 4;
    localparam int HANDLE_LIMIT = 16;
    localparam int PORT_BITS    = 16;
    localparam logic [PORT_BITS:0] PORT_SPACE = 17'h10000;

    typedef enum logic [1:0] {
        REQ_RESERVE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_ACCESS  = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_RANGE   = 3'd2,
        STAT_BUSY    = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    // request fields broadcast to every cell
    typedef struct packed {
        logic [PORT_BITS-1:0]   first;
        logic [PORT_BITS-1:0]   last;
        logic [PORT_BITS-1:0]   length;
        logic [HANDLE_BITS-1:0] handle;
    } bcast_t;

    // table update issued when a word completes
    typedef struct packed {
        logic                   set;
        logic                   clr;
        logic [HANDLE_BITS-1:0] slot;
    } wr_t;

    // partial result handed from cell to cell
    typedef struct packed {
        logic                   busy;
        logic                   found;
        logic [HANDLE_BITS-1:0] idx;
        logic                   hit;
        logic [PORT_BITS-1:0]   base;
        logic [PORT_BITS-1:0]   length;
    } chain_t;

endpackage

>>> rtl/prrt_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on nothing.
interface prrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] range_base;
    logic [15:0] range_length;
    logic [3:0]  slot_handle;
    logic [15:0] port_offset;
    logic [7:0]  access_width;

    modport source (
        output valid, req_type, range_base, range_length,
               slot_handle, port_offset, access_width,
        input  ready
    );
    modport sink (
        input  valid, req_type, range_base, range_length,
               slot_handle, port_offset, access_width,
        output ready
    );
endinterface

>>> rtl/prrt_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on nothing.
interface prrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  granted_slot;
    logic [15:0] port_address;

    modport source (
        output valid, status, granted_slot, port_address,
        input  ready
    );
    modport sink (
        input  valid, status, granted_slot, port_address,
        output ready
    );
endinterface

>>> rtl/prrt_cell.sv
// One table slot: holds valid, base, length and end, and folds its own
// checks into the chain word from its lower neighbor. Depends on prrt_pkg.
module prrt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  prrt_pkg::bcast_t bcast,
    input  prrt_pkg::wr_t    wr,
    input  prrt_pkg::chain_t chain_in,
    output prrt_pkg::chain_t chain_out
);
    import prrt_pkg::*;

    localparam logic [HANDLE_BITS-1:0] MY_IDX = HANDLE_BITS'(CELL_IDX);
    localparam bit NAMED = (CELL_IDX < HANDLE_LIMIT);

    logic                 valid_reg;
    logic [PORT_BITS-1:0] base_reg;
    logic [PORT_BITS-1:0] len_reg;
    logic [PORT_BITS-1:0] end_reg;
    chain_t               chain_reg;
    chain_t               chain_next;
    logic                 selected;
    logic                 overlap;

    assign selected = NAMED && (wr.slot == MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (selected && wr.set)
        begin
            valid_reg <= 1'b1;
        end
        else if (selected && wr.clr)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (selected && wr.set)
        begin
            base_reg <= bcast.first;
            len_reg  <= bcast.length;
            end_reg  <= bcast.last;
        end
    end

    // inclusive spans meet unless one ends before the other starts
    assign overlap = valid_reg && !((bcast.last < base_reg) || (end_reg < bcast.first));

    always_comb
    begin
        chain_next      = chain_in;
        chain_next.busy = chain_in.busy | overlap;
        if (!chain_in.found && !valid_reg && NAMED)
        begin
            chain_next.found = 1'b1;
            chain_next.idx   = MY_IDX;
        end
        if (NAMED && (bcast.handle == MY_IDX))
        begin
            chain_next.hit    = valid_reg;
            chain_next.base   = base_reg;
            chain_next.length = len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

>>> rtl/port_range_reservation_table.sv
// Port range reservation table. Holds REGION_SLOTS reserved ranges of 16-bit
// port addresses in a row of slot cells. Request words: reserve a range (gets
// the lowest free slot below 16 as a handle, or busy / full), release a slot,
// or check an access of width 1, 2 or 4 at an offset in a slot's region,
// returning the port address. The request is held and broadcast while a
// registered partial result (overlap seen, lowest free slot, selected
// slot's region) walks one cell per cycle to the end of the row; the last
// cycle forms the result and updates the table once the output register is
// free. A new word is taken only once the previous one is finished and the
// sequencer is back in idle. A finished result sits in an output register,
// so the next request is taken as soon as the chain is free even if the
// previous result is still waiting. Reserve and release are refused while
// manager_enabled (cfg_wr_en / cfg_wr_data, reset 0) is low; access checks
// are not. Config is to be written only while idle; the block itself does
// not enforce this.
// Depends on prrt_pkg, prrt_req_if, prrt_rsp_if and prrt_cell.
module port_range_reservation_table #(
    parameter int REGION_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    prrt_req_if.sink     req,
    prrt_rsp_if.source   rsp,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);
    import prrt_pkg::*;

    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam logic [CW-1:0] CNT_DONE = CW'(REGION_SLOTS);

    // state and held request word
    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 en_reg;
    req_type_t            type_reg;
    logic [PORT_BITS-1:0] base_reg;
    logic [PORT_BITS-1:0] len_reg;
    logic [3:0]           handle_reg;
    logic [PORT_BITS-1:0] offset_reg;
    logic [7:0]           width_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [3:0]           out_slot_reg, out_slot_next;
    logic [PORT_BITS-1:0] out_addr_reg, out_addr_next;

    bcast_t               bcast;
    wr_t                  wr;
    chain_t               chain [REGION_SLOTS+1];
    chain_t               tail;
    logic                 accept;
    logic                 out_free;
    logic [PORT_BITS:0]   reserve_end;
    logic [PORT_BITS:0]   access_end;
    logic                 width_ok;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            en_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req_type_t'(req.req_type);
            base_reg   <= req.range_base;
            len_reg    <= req.range_length;
            handle_reg <= req.slot_handle;
            offset_reg <= req.port_offset;
            width_reg  <= req.access_width;
        end
    end

    // broadcast; last port is only meaningful once the range checks pass
    assign bcast.first  = base_reg;
    assign bcast.last   = base_reg + len_reg - 16'd1;
    assign bcast.length = len_reg;
    assign bcast.handle = handle_reg;

    // the cell row
    assign chain[0] = '0;
    generate
        for (genvar i = 0; i < REGION_SLOTS; i++)
        begin : g_cell
            prrt_cell #(
                .CELL_IDX (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .bcast     (bcast),
                .wr        (wr),
                .chain_in  (chain[i]),
                .chain_out (chain[i+1])
            );
        end
    endgenerate
    assign tail = chain[REGION_SLOTS];

    assign reserve_end = {1'b0, base_reg} + {1'b0, len_reg};
    assign access_end  = {1'b0, offset_reg} + {9'd0, width_reg};
    assign width_ok    = (width_reg == 8'd1) || (width_reg == 8'd2) || (width_reg == 8'd4);

    // sequencer: run the chain, then form the result and update the table
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_addr_next   = out_addr_reg;
        wr              = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    cnt_next   = '0;
                end
            end
            S_RUN:
            begin
                if (cnt_reg != CNT_DONE)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_INVALID;
                    out_slot_next   = '0;
                    out_addr_next   = '0;
                    unique case (type_reg)
                        REQ_RESERVE:
                        begin
                            priority if (!en_reg || (len_reg == '0))
                            begin
                                out_status_next = STAT_INVALID;
                            end
                            else if (reserve_end > PORT_SPACE)
                            begin
                                out_status_next = STAT_RANGE;
                            end
                            else if (tail.busy)
                            begin
                                out_status_next = STAT_BUSY;
                            end
                            else if (!tail.found)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                out_status_next = STAT_OK;
                                out_slot_next   = tail.idx;
                                wr.set          = 1'b1;
                                wr.slot         = tail.idx;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (en_reg && tail.hit)
                            begin
                                out_status_next = STAT_OK;
                                wr.clr          = 1'b1;
                                wr.slot         = handle_reg;
                            end
                        end
                        REQ_ACCESS:
                        begin
                            if (tail.hit && width_ok)
                            begin
                                if (access_end > {1'b0, tail.length})
                                begin
                                    out_status_next = STAT_RANGE;
                                end
                                else
                                begin
                                    out_status_next = STAT_OK;
                                    out_addr_next   = tail.base + offset_reg;
                                end
                            end
                        end
                        REQ_UNUSED:
                        begin
                            out_status_next = STAT_INVALID;
                        end
                        default:
                        begin
                            out_status_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_addr_reg   <= out_addr_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_slot = out_slot_reg;
    assign rsp.port_address = out_addr_reg;

endmodule
